>>> rtl/assert_macros.svh
// assertion macros of the csma/ca backoff sender rtl
// no dependencies; include by bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define CSMAB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// mutual exclusion of a group of bits on every rising edge outside reset
`define CSMAB_ASSERT_ONEHOT0(label, bits, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot0(bits)) \
        else $error(msg);

`endif

>>> rtl/csmab_pkg.sv
// types, codes and constants of the csma/ca backoff sender
// no dependencies; imported by every module of the block
`default_nettype none

package csmab_pkg;

    localparam int BACKOFF_WIDTH   = 24;
    localparam int BACKOFF_LEFT_W  = 24;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int RND_W           = 15;
    localparam int DRAW_W          = 23;
    localparam int WIDE_W          = 33;

    localparam logic [WIDE_W-1:0] BACKOFF_MAX =
        (WIDE_W'(1) << BACKOFF_WIDTH) - WIDE_W'(1);

    typedef logic [BACKOFF_WIDTH-1:0] t_backoff;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DIFS    = 3'd1,
        PH_BACKOFF = 3'd2,
        PH_BUSY    = 3'd3,
        PH_WAITACK = 3'd4,
        PH_JUDGE   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        CH_FREE     = 2'd0,
        CH_BUSY     = 2'd1,
        CH_CONFLICT = 2'd2
    } t_channel;

    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_START    = 3'd1,
        REQ_BUSY     = 3'd2,
        REQ_CONFLICT = 3'd3,
        REQ_ACK      = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        REG_DIFS      = 3'd0,
        REG_SIFS      = 3'd1,
        REG_SLICE     = 3'd2,
        REG_BUSY_HOLD = 3'd3,
        REG_MAX_RETRY = 3'd4
    } t_reg_idx;

    localparam logic [15:0] DIFS_RST      = 16'd50;
    localparam logic [7:0]  SIFS_RST      = 8'd10;
    localparam logic [15:0] SLICE_RST     = 16'd100;
    localparam logic [15:0] BUSY_HOLD_RST = 16'd8000;
    localparam logic [3:0]  MAX_RETRY_RST = 4'd6;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [14:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  sender_phase;
        logic [1:0]  channel_code;
        logic        transmit;
        logic        send_ok;
        logic        send_failed;
        logic [23:0] backoff_left;
        logic [3:0]  retry_count;
    } t_out_item;

    typedef struct packed {
        logic [15:0] difs_ms;
        logic [7:0]  sifs_ms;
        logic [15:0] slice_ms;
        logic [15:0] busy_hold_ms;
        logic [3:0]  max_retries;
    } t_cfg;

    // low (retries + 2) bits of the random draw
    function automatic logic [RND_W-1:0] f_draw_mask(input logic [3:0] retries);
        logic [17:0] m;
        m = (18'd1 << ({1'b0, retries} + 5'd2)) - 18'd1;
        return m[RND_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/csmab_cfg.sv
// apb-style configuration registers of the csma/ca backoff sender
// depends on csmab_pkg
`default_nettype none

module csmab_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [csmab_pkg::ADDR_W-1:0] paddr,
    input  wire logic [csmab_pkg::DATA_W-1:0] pwdata,
    output logic      [csmab_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output csmab_pkg::t_cfg                  o_cfg
);
    import csmab_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.difs_ms      <= DIFS_RST;
            r_cfg.sifs_ms      <= SIFS_RST;
            r_cfg.slice_ms     <= SLICE_RST;
            r_cfg.busy_hold_ms <= BUSY_HOLD_RST;
            r_cfg.max_retries  <= MAX_RETRY_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DIFS:      r_cfg.difs_ms      <= pwdata[15:0];
                REG_SIFS:      r_cfg.sifs_ms      <= pwdata[7:0];
                REG_SLICE:     r_cfg.slice_ms     <= pwdata[15:0];
                REG_BUSY_HOLD: r_cfg.busy_hold_ms <= pwdata[15:0];
                REG_MAX_RETRY: r_cfg.max_retries  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DIFS:      prdata = DATA_W'(r_cfg.difs_ms);
            REG_SIFS:      prdata = DATA_W'(r_cfg.sifs_ms);
            REG_SLICE:     prdata = DATA_W'(r_cfg.slice_ms);
            REG_BUSY_HOLD: prdata = DATA_W'(r_cfg.busy_hold_ms);
            REG_MAX_RETRY: prdata = DATA_W'(r_cfg.max_retries);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/csmab_core.sv
// sender state registers and the single-pass update for one transaction
// depends on csmab_pkg and assert_macros.svh
`default_nettype none

module csmab_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire csmab_pkg::t_in_item i_item,
    input  wire csmab_pkg::t_cfg   i_cfg,
    output csmab_pkg::t_out_item   o_result
);
    import csmab_pkg::*;
    `include "assert_macros.svh"

    t_phase      r_phase,   n_phase;
    t_channel    r_ch,      n_ch;
    logic [15:0] r_age,     n_age;
    logic [15:0] r_wait,    n_wait;
    t_backoff    r_bo,      n_bo;
    logic [3:0]  r_retries, n_retries;

    logic              w_tx, w_ok, w_fail;
    t_channel          w_tick_ch;
    logic [15:0]       w_tick_age;
    logic [15:0]       w_slice;
    logic [3:0]        w_retry_inc;
    logic              w_retry_fail;
    logic [DRAW_W-1:0] w_draw;
    logic [WIDE_W-1:0] w_draw_wide;
    t_backoff          w_draw_sat;
    t_backoff          w_bo_dec;

    // channel aging on a tick
    always_comb begin
        w_tick_ch  = r_ch;
        w_tick_age = r_age;
        if (r_ch != CH_FREE) begin
            if (r_age != 16'hFFFF) begin
                w_tick_age = r_age + 16'd1;
            end
            if (r_ch == CH_BUSY && w_tick_age >= i_cfg.busy_hold_ms) begin
                w_tick_ch = CH_FREE;
            end
        end
    end

    assign w_slice      = (i_cfg.slice_ms == 16'd0) ? 16'd1 : i_cfg.slice_ms;
    assign w_retry_inc  = (r_retries != 4'hF) ? r_retries + 4'd1 : r_retries;
    assign w_retry_fail = w_retry_inc > i_cfg.max_retries;
    assign w_draw       = DRAW_W'(i_item.random_value & f_draw_mask(w_retry_inc))
                        * DRAW_W'(i_cfg.sifs_ms);
    assign w_draw_wide  = WIDE_W'(w_draw);
    assign w_draw_sat   = BACKOFF_WIDTH'((w_draw_wide > BACKOFF_MAX) ? BACKOFF_MAX
                                                                     : w_draw_wide);
    assign w_bo_dec     = (r_bo > BACKOFF_WIDTH'(w_slice)) ? r_bo - BACKOFF_WIDTH'(w_slice)
                                                           : '0;

    always_comb begin
        n_phase   = r_phase;
        n_ch      = r_ch;
        n_age     = r_age;
        n_wait    = r_wait;
        n_bo      = r_bo;
        n_retries = r_retries;
        w_tx      = 1'b0;
        w_ok      = 1'b0;
        w_fail    = 1'b0;
        case (t_req'(i_item.req_type))
            REQ_TICK: begin
                n_ch  = w_tick_ch;
                n_age = w_tick_age;
                unique case (r_phase) inside
                    PH_JUDGE, PH_BUSY: begin
                        if (w_tick_ch == CH_BUSY) begin
                            n_phase = PH_BUSY;
                        end else begin
                            if (w_tick_ch == CH_CONFLICT) begin
                                n_ch  = CH_FREE;
                                n_age = '0;
                            end
                            n_phase = PH_DIFS;
                            n_wait  = i_cfg.difs_ms;
                        end
                    end
                    PH_DIFS: begin
                        if (r_wait > 16'd1) begin
                            n_wait = r_wait - 16'd1;
                        end else if (r_bo == '0) begin
                            w_tx    = 1'b1;
                            n_phase = PH_WAITACK;
                            n_wait  = '0;
                        end else begin
                            n_phase = PH_BACKOFF;
                            n_wait  = w_slice;
                        end
                    end
                    PH_BACKOFF: begin
                        if (r_wait > 16'd1) begin
                            n_wait = r_wait - 16'd1;
                        end else if (w_tick_ch == CH_FREE) begin
                            n_bo = w_bo_dec;
                            if (w_bo_dec == '0) begin
                                w_tx    = 1'b1;
                                n_phase = PH_WAITACK;
                                n_wait  = '0;
                            end else begin
                                n_phase = PH_BACKOFF;
                                n_wait  = w_slice;
                            end
                        end else if (w_tick_ch == CH_BUSY) begin
                            n_phase = PH_BUSY;
                            n_wait  = '0;
                        end else begin
                            // conflict seen at slice end: clear it and restart difs
                            n_ch    = CH_FREE;
                            n_age   = '0;
                            n_phase = PH_DIFS;
                            n_wait  = i_cfg.difs_ms;
                        end
                    end
                    PH_WAITACK: begin
                        // stale conflict counts like a fresh one
                        if (w_tick_ch == CH_CONFLICT) begin
                            n_retries = w_retry_inc;
                            if (w_retry_fail) begin
                                w_fail  = 1'b1;
                                n_phase = PH_IDLE;
                            end else begin
                                n_bo    = w_draw_sat;
                                n_phase = PH_JUDGE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            REQ_START: begin
                if (r_phase == PH_IDLE) begin
                    n_retries = '0;
                    n_bo      = '0;
                    n_wait    = '0;
                    n_phase   = PH_JUDGE;
                end
            end
            REQ_BUSY: begin
                n_ch  = CH_BUSY;
                n_age = '0;
            end
            REQ_CONFLICT: begin
                n_ch  = CH_CONFLICT;
                n_age = '0;
                if (r_phase == PH_WAITACK) begin
                    n_retries = w_retry_inc;
                    if (w_retry_fail) begin
                        w_fail  = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_bo    = w_draw_sat;
                        n_phase = PH_JUDGE;
                    end
                end
            end
            REQ_ACK: begin
                if (r_phase == PH_WAITACK) begin
                    w_ok    = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_ch      <= CH_FREE;
            r_age     <= '0;
            r_wait    <= '0;
            r_bo      <= '0;
            r_retries <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_ch      <= n_ch;
            r_age     <= n_age;
            r_wait    <= n_wait;
            r_bo      <= n_bo;
            r_retries <= n_retries;
        end
    end

    always_comb begin
        o_result.sender_phase = n_phase;
        o_result.channel_code = n_ch;
        o_result.transmit     = w_tx;
        o_result.send_ok      = w_ok;
        o_result.send_failed  = w_fail;
        o_result.backoff_left = BACKOFF_LEFT_W'(n_bo);
        o_result.retry_count  = n_retries;
    end

    `CSMAB_ASSERT(a_tx_enters_waitack,
        i_fire && w_tx |-> n_phase == PH_WAITACK && n_bo == '0,
        "transmit without entering wait ack with spent backoff")
    `CSMAB_ASSERT(a_fail_over_limit,
        i_fire && w_fail |=> r_phase == PH_IDLE && r_retries > i_cfg.max_retries,
        "send failure without exceeding the retry limit")
    `CSMAB_ASSERT_ONEHOT0(a_pulses_exclusive, {w_tx, w_ok, w_fail},
        "more than one event pulse in one transaction")

endmodule

`default_nettype wire

>>> rtl/csma_ca_backoff_sender.sv
// csma/ca sender controller: input register, single-pass state update, result register
// a transaction goes from the input register through the core into the result register
// throughput: one transaction per cycle while the result register is not stalled
// reset: synchronous active-low i_rst_n; idle phase, free channel, counters zero,
//        registers back to difs 50, sifs 10, slice 100, busy hold 8000, retries 6
// depends on csmab_pkg, csmab_cfg and csmab_core
`default_nettype none

module csma_ca_backoff_sender (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input transaction channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire csmab_pkg::t_in_item           i_in_data,
    // result transaction channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output csmab_pkg::t_out_item               o_out_data,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [csmab_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [csmab_pkg::DATA_W-1:0]  pwdata,
    output logic      [csmab_pkg::DATA_W-1:0]  prdata,
    output logic                               pready
);
    import csmab_pkg::*;

    // input register holds one transaction until the core consumes it
    logic      r_in_vld;
    t_in_item  r_in_item;
    // result register parts the core from the downstream consumer
    logic      r_out_vld;
    t_out_item r_out_item;

    logic      w_fire;
    t_cfg      w_cfg;
    t_out_item w_result;

    // with a transaction waiting, the core updates state when the result register
    // can take the result, either empty or being drained in this very cycle
    assign w_fire     = r_in_vld && (!r_out_vld || i_out_ready);
    // new transaction may enter whenever the input register empties this cycle
    assign o_in_ready = !r_in_vld || w_fire;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_item;

    csmab_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    csmab_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // valid flags of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

endmodule

`default_nettype wire
